@@ hdl/cht_pkg.sv @@
`timescale 1ns / 1ps

package cht_pkg;

  localparam int unsigned CfgWidth   = 9;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned TotalBits  = 11;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic                 full_res;
    logic [TotalBits-1:0] entry_total;
  } rsp_t;

endpackage

@@ hdl/chained_hash_table.sv @@
`timescale 1ns / 1ps

// Key/value table with separate chaining over a fixed node pool.
// A request on the in channel (in_valid_i, in_stall_o, in_req_i) carries a
// kind (set, lookup, remove, clear), a key and a value. Each request gives
// exactly one response on the out channel (out_valid_o, out_stall_i,
// out_rsp_o) with the found and full flags and the entry count afterwards.
// The bucket is the key modulo the bucket count register, read as one when
// zero and as NUM_BUCKETS when larger. The user must write that register
// through cfg_we_i and cfg_wdata_i only while no request is in flight; the
// block does not enforce this. The block serves one request at a time. The
// modulo unit resolves four key bits per cycle; the block then reads the
// bucket head, walks the chain one node at a time, updates the table (and
// for a new entry allocates and links a node) and loads the response.
// A clear request goes straight to loading the response.
// The response register lets the next request be taken while a response is
// stalled; a finished request waits until that register is free.
// Reset empties every bucket, frees the whole pool, zeroes the entry count
// and sets the bucket count to one. No clearing pass over the memories runs.

module chained_hash_table #(
  parameter int unsigned NUM_BUCKETS = 256,
  parameter int unsigned POOL_SIZE   = 1024,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cht_pkg::CfgWidth-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  cht_pkg::req_t                    in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output cht_pkg::rsp_t                    out_rsp_o
);

  localparam int unsigned LW     = $clog2(POOL_SIZE + 1);
  localparam int unsigned PW     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned DW     = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned KP     = ((KEY_WIDTH + 3) / 4) * 4;
  localparam int unsigned DSTEPS = KP / 4;
  localparam int unsigned SW     = (DSTEPS > 1) ? $clog2(DSTEPS) : 1;
  localparam logic [LW-1:0] NIL  = LW'(POOL_SIZE);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV   = 9'b000000010,
    ST_HEAD  = 9'b000000100,
    ST_HWAIT = 9'b000001000,
    ST_NWAIT = 9'b000010000,
    ST_ACT   = 9'b000100000,
    ST_ALLOC = 9'b001000000,
    ST_LINK  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e                  state_q;
  logic [cht_pkg::CfgWidth-1:0] cfg_q;
  cht_pkg::func_e          func_q;
  logic [KEY_WIDTH-1:0]    key_q;
  logic [VALUE_WIDTH-1:0]  value_q;
  logic [DW-1:0]           rem_q, rem_d;
  logic [KP-1:0]           kshift_q, kshift_d;
  logic [SW-1:0]           step_q;
  logic [DW-1:0]           div_q, div_eff;
  logic [BW-1:0]           bucket_q;
  logic [LW-1:0]           cur_q, prev_q, nxt_q;
  logic [PW-1:0]           newn_q, newn_d;
  logic                    found_q, full_q;
  logic [LW-1:0]           free_top_q, lwm_q, count_q;
  logic [NUM_BUCKETS-1:0]  head_valid_q;
  logic                    out_valid_q;
  cht_pkg::rsp_t           out_rsp_q;

  logic [LW-1:0]           head_mem [NUM_BUCKETS];
  logic [KEY_WIDTH-1:0]    key_mem [POOL_SIZE];
  logic [VALUE_WIDTH-1:0]  value_mem [POOL_SIZE];
  logic [LW-1:0]           link_mem [POOL_SIZE];
  logic [PW-1:0]           fs_mem [POOL_SIZE];

  logic [LW-1:0]           head_rd, link_rd, hw_cur;
  logic [KEY_WIDTH-1:0]    key_rd;
  logic [PW-1:0]           fs_rd;
  logic [PW-1:0]           node_raddr, fs_raddr;

  logic                    head_we;
  logic [LW-1:0]           head_wdata;
  logic                    kv_we, val_we, link_we, fs_we;
  logic [PW-1:0]           kv_waddr, val_waddr, link_waddr;
  logic [LW-1:0]           link_wdata;

  logic                    in_accept, rsp_load;
  logic                    cur_nil, link_nil, hw_nil;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign rsp_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_rsp_q;

  assign hw_cur   = head_valid_q[bucket_q] ? head_rd : NIL;
  assign hw_nil   = (hw_cur >= NIL);
  assign link_nil = (link_rd >= NIL);
  assign cur_nil  = (prev_q >= NIL);

  always_comb begin
    div_eff = DW'(cfg_q);
    if (cfg_q == '0) begin
      div_eff = DW'(1);
    end else if (32'(cfg_q) > 32'(NUM_BUCKETS)) begin
      div_eff = DW'(NUM_BUCKETS);
    end
  end

  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [KP-1:0] ks;
    r  = rem_q;
    ks = kshift_q;
    for (int i = 0; i < 4; i++) begin
      t  = {r, ks[KP-1]};
      ks = ks << 1;
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t[DW-1:0];
    end
    rem_d    = r;
    kshift_d = ks;
  end

  assign node_raddr = (state_q == ST_HWAIT) ? hw_cur[PW-1:0] : link_rd[PW-1:0];
  assign fs_raddr   = PW'(free_top_q - LW'(1));
  assign newn_d     = (free_top_q == lwm_q) ? PW'(NIL - free_top_q) : fs_rd;

  always_comb begin
    head_we    = 1'b0;
    head_wdata = nxt_q;
    kv_we      = 1'b0;
    kv_waddr   = newn_d;
    val_we     = 1'b0;
    val_waddr  = newn_d;
    link_we    = 1'b0;
    link_waddr = newn_d;
    link_wdata = NIL;
    fs_we      = 1'b0;
    case (state_q)
      ST_ACT: begin
        if (func_q == cht_pkg::FUNC_SET && found_q) begin
          val_we    = 1'b1;
          val_waddr = cur_q[PW-1:0];
        end else if (func_q == cht_pkg::FUNC_REMOVE && found_q) begin
          fs_we = (free_top_q < NIL);
          if (cur_nil) begin
            head_we = 1'b1;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_q[PW-1:0];
            link_wdata = nxt_q;
          end
        end
      end
      ST_ALLOC: begin
        kv_we   = 1'b1;
        val_we  = 1'b1;
        link_we = 1'b1;
      end
      ST_LINK: begin
        head_wdata = LW'(newn_q);
        if (cur_nil) begin
          head_we = 1'b1;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q[PW-1:0];
          link_wdata = LW'(newn_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bucket_q] <= head_wdata;
    end
    head_rd <= head_mem[bucket_q];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[kv_waddr] <= key_q;
    end
    key_rd <= key_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      value_mem[val_waddr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd <= link_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[free_top_q[PW-1:0]] <= cur_q[PW-1:0];
    end
    fs_rd <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cht_pkg::CfgWidth'(1);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        func_q   <= in_req_i.func;
        key_q    <= KEY_WIDTH'(in_req_i.key);
        value_q  <= VALUE_WIDTH'(in_req_i.value);
        rem_q    <= '0;
        kshift_q <= KP'(KEY_WIDTH'(in_req_i.key));
        step_q   <= SW'(DSTEPS - 1);
        div_q    <= div_eff;
      end
      ST_DIV: begin
        rem_q    <= rem_d;
        kshift_q <= kshift_d;
        step_q   <= step_q - SW'(1);
        bucket_q <= rem_d[BW-1:0];
      end
      ST_HWAIT: begin
        prev_q <= NIL;
        cur_q  <= hw_cur;
      end
      ST_NWAIT: begin
        nxt_q <= link_rd;
        if (key_rd != key_q) begin
          prev_q <= cur_q;
          cur_q  <= link_rd;
        end
      end
      ST_ALLOC: begin
        newn_q <= newn_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      found_q      <= 1'b0;
      full_q       <= 1'b0;
      free_top_q   <= NIL;
      lwm_q        <= NIL;
      count_q      <= '0;
      head_valid_q <= '0;
      out_valid_q  <= 1'b0;
      out_rsp_q    <= '0;
    end else begin
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            found_q <= 1'b0;
            full_q  <= 1'b0;
            if (in_req_i.func == cht_pkg::FUNC_CLEAR) begin
              head_valid_q <= '0;
              free_top_q   <= NIL;
              lwm_q        <= NIL;
              count_q      <= '0;
              state_q      <= ST_DONE;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          state_q <= ST_HWAIT;
        end
        ST_HWAIT: begin
          state_q <= hw_nil ? ST_ACT : ST_NWAIT;
        end
        ST_NWAIT: begin
          if (key_rd == key_q) begin
            found_q <= 1'b1;
            state_q <= ST_ACT;
          end else if (link_nil) begin
            state_q <= ST_ACT;
          end
        end
        ST_ACT: begin
          state_q <= ST_DONE;
          if (func_q == cht_pkg::FUNC_SET && !found_q) begin
            if (free_top_q == '0) begin
              full_q <= 1'b1;
            end else begin
              state_q <= ST_ALLOC;
            end
          end else if (func_q == cht_pkg::FUNC_REMOVE && found_q) begin
            if (free_top_q < NIL) begin
              free_top_q <= free_top_q + LW'(1);
            end
            if (count_q != '0) begin
              count_q <= count_q - LW'(1);
            end
          end
        end
        ST_ALLOC: begin
          free_top_q <= free_top_q - LW'(1);
          if (free_top_q == lwm_q) begin
            lwm_q <= lwm_q - LW'(1);
          end
          count_q <= count_q + LW'(1);
          state_q <= ST_LINK;
        end
        ST_LINK: begin
          if (cur_nil) begin
            head_valid_q[bucket_q] <= 1'b1;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_load) begin
            out_rsp_q.found       <= found_q;
            out_rsp_q.full_res    <= full_q;
            out_rsp_q.entry_total <= cht_pkg::TotalBits'(count_q);
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, free_top_q} + {1'b0, count_q}) == (LW + 1)'(POOL_SIZE))
    else $error("free pool and entry count disagree");

  a_lwm_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lwm_q <= free_top_q)
    else $error("free stack low mark above stack top");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_req_i.func == cht_pkg::FUNC_CLEAR) |=>
      (count_q == '0 && head_valid_q == '0))
    else $error("clear request left entries behind");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.found && out_rsp_o.full_res))
    else $error("response flags both found and full");

  a_load_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("response loaded outside the done state");

endmodule

@@ verif/cht_checker.sv @@
`timescale 1ns / 1ps

module cht_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cht_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  cht_pkg::req_t                in_req_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  cht_pkg::rsp_t                out_rsp_o,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           rsp_seen_o
);

  localparam int unsigned Buckets = 256;
  localparam int unsigned Pool    = 1024;
  localparam int unsigned Nil     = Pool;

  logic [cht_pkg::CfgWidth-1:0] bucket_cnt;
  int unsigned         head_q [Buckets];
  logic [31:0]         key_q  [Pool];
  logic [31:0]         val_q  [Pool];
  int unsigned         link_q [Pool];
  int unsigned         free_q [Pool];
  int unsigned         free_top;
  int unsigned         entries;
  cht_pkg::rsp_t       expected_rsps [$];

  function automatic void empty_table();
    for (int i = 0; i < Buckets; i++) head_q[i] = Nil;
    for (int i = 0; i < Pool; i++) free_q[i] = Pool - 1 - i;
    free_top = Pool;
    entries  = 0;
  endfunction

  function automatic cht_pkg::rsp_t apply_request(cht_pkg::req_t r);
    cht_pkg::rsp_t res;
    int unsigned   n, b, prev, cur, steps, slot;
    res = '0;
    if (r.func == cht_pkg::FUNC_CLEAR) begin
      empty_table();
    end else begin
      n = bucket_cnt;
      if (n == 0) n = 1;
      if (n > Buckets) n = Buckets;
      b = r.key % n;
      prev = Nil;
      cur = head_q[b];
      steps = 0;
      while (cur < Pool && steps < Pool) begin
        if (key_q[cur] == r.key) begin
          res.found = 1'b1;
          break;
        end
        prev = cur;
        cur = link_q[cur];
        steps++;
      end
      if (r.func == cht_pkg::FUNC_SET) begin
        if (res.found) begin
          val_q[cur] = r.value;
        end else if (free_top == 0) begin
          res.full_res = 1'b1;
        end else begin
          free_top--;
          slot = free_q[free_top];
          key_q[slot] = r.key;
          val_q[slot] = r.value;
          link_q[slot] = Nil;
          if (prev < Pool) link_q[prev] = slot;
          else head_q[b] = slot;
          entries++;
        end
      end else if (r.func == cht_pkg::FUNC_REMOVE && res.found) begin
        if (prev < Pool) link_q[prev] = link_q[cur];
        else head_q[b] = link_q[cur];
        if (free_top < Pool) begin
          free_q[free_top] = cur;
          free_top++;
        end
        if (entries > 0) entries--;
      end
    end
    res.entry_total = entries[cht_pkg::TotalBits-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cht_pkg::rsp_t want;
    if (!rst_ni) begin
      bucket_cnt = cht_pkg::CfgWidth'(1);
      empty_table();
      expected_rsps.delete();
      fail_count_o <= 0;
      rsp_seen_o <= 0;
    end else begin
      if (cfg_we_i) bucket_cnt = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) expected_rsps.push_back(apply_request(in_req_i));
      if (out_valid_o && !out_stall_i) begin
        rsp_seen_o <= rsp_seen_o + 1;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %p", $time, out_rsp_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (want !== out_rsp_o) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_rsp_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o <= expected_rsps.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [cht_pkg::CfgWidth-1:0] cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  cht_pkg::req_t                in_req = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  cht_pkg::rsp_t                out_rsp;
  int                           fail_count, pending, rsp_seen;
  int                           cycles = 0;
  bit                           quiet = 1'b0;
  int                           sent = 0;
  logic [31:0]                  key_pool [16];

  always #4 clk = ~clk;

  chained_hash_table dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp)
  );

  cht_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp),
    .fail_count_o(fail_count), .pending_o(pending), .rsp_seen_o(rsp_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (quiet || $urandom_range(0, 3) != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(cht_pkg::func_e f, logic [31:0] k, logic [31:0] v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_req <= '{func: f, key: k, value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_buckets(logic [cht_pkg::CfgWidth-1:0] n);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, int key_span);
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 7) == 0) ? $urandom() : key_pool[$urandom_range(0, key_span)];
      case ($urandom_range(0, 19))
        0:                   send_request(cht_pkg::FUNC_CLEAR, $urandom(), $urandom());
        1, 2, 3, 4, 5, 6, 7: send_request(cht_pkg::FUNC_SET, k, $urandom());
        8, 9, 10, 11, 12:    send_request(cht_pkg::FUNC_LOOKUP, k, $urandom());
        default:             send_request(cht_pkg::FUNC_REMOVE, k, $urandom());
      endcase
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = (i < 2) ? (i == 0 ? 32'h0 : 32'hFFFF_FFFF) : $urandom();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(cht_pkg::FUNC_LOOKUP, 32'h0, 32'h0);
    send_request(cht_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(cht_pkg::FUNC_SET, 32'h0, 32'hFFFF_FFFF);
    send_request(cht_pkg::FUNC_SET, 32'hFFFF_FFFF, 32'h0);
    send_request(cht_pkg::FUNC_SET, 32'h0, 32'h1234_5678);
    send_request(cht_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(cht_pkg::FUNC_SET, 32'h5, 32'h1);
    send_request(cht_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(cht_pkg::FUNC_LOOKUP, 32'h5, 32'h0);
    write_buckets(9'd7);
    send_request(cht_pkg::FUNC_LOOKUP, 32'h5, 32'h0);
    send_request(cht_pkg::FUNC_REMOVE, 32'h0, 32'h0);
    send_request(cht_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(cht_pkg::FUNC_LOOKUP, 32'h0, 32'h0);

    write_buckets(9'd256);
    send_request(cht_pkg::FUNC_SET, 32'h1, 32'h2);
    send_request(cht_pkg::FUNC_SET, 32'h0, 32'h2);
    send_request(cht_pkg::FUNC_REMOVE, 32'h3, 32'h0);
    send_request(cht_pkg::FUNC_SET, 32'hFFFF_FFFF, 32'h0);
    send_request(cht_pkg::FUNC_CLEAR, 32'h0, 32'h0);

    write_buckets(9'd0);
    random_phase(120, 7);
    write_buckets(9'd300);
    random_phase(120, 15);
    write_buckets(9'd3);
    random_phase(120, 15);
    write_buckets(9'h1FF);
    random_phase(120, 15);
    write_buckets(9'd1);
    random_phase(100, 15);
    quiet = 1'b1;
    random_phase(100, 15);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d requests over several bucket counts, out-of-range ones included,",
             sent);
    $display("with clears mixed in; %0d responses checked.", rsp_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
